>>> rtl/ncea_pkg.sv
// ----------------------------------------------------------------------------
// ncea_pkg: shared definitions for the nearest-center EMD assignment block
// Sizes, derived widths, register indexes and the structs that pass between
// the sequencer and the distance unit.
// ----------------------------------------------------------------------------
package ncea_pkg;

   localparam int MAX_CENTERS = 256;
   localparam int MAX_BINS    = 64;
   localparam int VALUE_BITS  = 16;

   // Port field widths
   localparam int CI_W   = 8;
   localparam int BI_W   = 6;
   localparam int BV_W   = 16;
   localparam int DIST_W = 32;

   // Stored value width: the bin_value field, masked to VALUE_BITS
   localparam int VAL_W = (VALUE_BITS < BV_W) ? VALUE_BITS : BV_W;

   localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
   localparam int BCNT_W = $clog2(MAX_BINS + 1);
   localparam int CCNT_W = $clog2(MAX_CENTERS + 1);

   localparam int CMEM_DEPTH = MAX_CENTERS * MAX_BINS;
   localparam int ADDR_W     = $clog2(CMEM_DEPTH);

   // Running difference is signed, sum of magnitudes unsigned
   localparam int RUN_W  = VAL_W + BIN_W + 1;
   localparam int SUM_W  = VAL_W + 2 * BIN_W;
   localparam int SUMX_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;
   localparam int CFG_C_W    = 9;
   localparam int CFG_B_W    = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTERS_IN_USE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_IN_USE    = CSR_IDX_W'(1);

   localparam logic KIND_CENTER = 1'b0;
   localparam logic KIND_POINT  = 1'b1;

   // Control that travels with each memory read
   typedef struct packed {
      logic              valid;
      logic              first_bin;
      logic              last_bin;
      logic              first_center;
      logic              last_center;
      logic [CIDX_W-1:0] center;
   } ncea_tag_type;

   // Running best from the distance unit
   typedef struct packed {
      logic              done;
      logic [CIDX_W-1:0] center;
      logic [SUM_W-1:0]  sum;
   } ncea_best_type;

endpackage

>>> rtl/ncea_emd_unit.sv
// ----------------------------------------------------------------------------
// ncea_emd_unit: shared distance accumulator and minimum tracker
// Takes one point bin and one center bin a cycle, keeps the running
// difference and the sum of its magnitude, and keeps the nearest center.
// ----------------------------------------------------------------------------
module ncea_emd_unit
   import ncea_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ncea_tag_type      tag,
   input  logic [VAL_W-1:0]  point_bin,
   input  logic [VAL_W-1:0]  center_bin,
   output ncea_best_type     best
);

   ncea_tag_type             tag1_ff, tag2_ff;
   logic signed [RUN_W-1:0]  run_ff, run_in;
   logic [SUM_W-1:0]         total_ff, total_in;
   logic [SUM_W-1:0]         mag;
   logic [SUM_W-1:0]         best_ff;
   logic [CIDX_W-1:0]        best_c_ff;
   logic                     done_ff;

   // Stage one: running difference
   always_comb begin
      run_in = (tag.first_bin ? '0 : run_ff)
             + $signed(RUN_W'(point_bin)) - $signed(RUN_W'(center_bin));
   end

   // Stage two: add the magnitude
   always_comb begin
      mag      = run_ff[RUN_W-1] ? SUM_W'(-run_ff) : SUM_W'(run_ff);
      total_in = (tag1_ff.first_bin ? '0 : total_ff) + mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         done_ff <= tag2_ff.valid && tag2_ff.last_bin && tag2_ff.last_center;
      end
      if (tag.valid) begin
         run_ff <= run_in;
      end
      if (tag1_ff.valid) begin
         total_ff <= total_in;
      end
      // Stage three: strict less keeps the lowest index on ties
      if (tag2_ff.valid && tag2_ff.last_bin &&
          (tag2_ff.first_center || total_ff < best_ff)) begin
         best_ff   <= total_ff;
         best_c_ff <= tag2_ff.center;
      end
   end

   assign best.done   = done_ff;
   assign best.center = best_c_ff;
   assign best.sum    = best_ff;

endmodule

>>> rtl/nearest_center_emd_assign_core.sv
// ----------------------------------------------------------------------------
// nearest_center_emd_assign_core: nearest center by 1-D earth mover's distance
// Stores center histograms and assigns each incoming point histogram to its
// closest center.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is a stream of bins. tuser = 0 loads one center bin into the
//   center memory, tuser = 1 writes one bin of the current point. A point bin
//   whose bin_index is bins_in_use - 1 closes the point and starts the search.
//   rsp_* carries one transfer per closed point: the nearest center (lowest
//   index on ties) and its distance, saturated to 32 bits.
//   csr_* writes centers_in_use (index 0) and bins_in_use (index 1); write
//   only while the block is idle. Values outside range saturate; bins_in_use keeps only csr_data[6:0].
// Timing:
//   Loads and non-final point bins are taken whenever req_tready is high. A
//   final point bin starts a search over every center in use before rsp_tvalid: the
//   single distance unit consumes one center bin per cycle from the center
//   memory's one read port. req_tready is low during that search.
// Reset: clears the control state; both memories keep whatever
//   they hold and need no clearing pass. Registers return to 1 and 64.
// Stall: a result waits in the output register; loads and point bins are
//   still taken meanwhile. A search that ends while the previous result is
//   still waiting holds until it is taken.
// ----------------------------------------------------------------------------
module nearest_center_emd_assign_core
   import ncea_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // center_index[7:0], bin_index[13:8],
                                              // bin_value[29:14], zero[31:30]
   input  logic                  req_tuser,   // kind[0]
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // nearest_center[7:0],
                                              // nearest_distance[39:8]
   // Configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PUSH
   } state_type;

   state_type state_ff;

   // Request fields
   logic [CI_W-1:0]  req_center;
   logic [BI_W-1:0]  req_bin;
   logic [VAL_W-1:0] req_value;
   logic             req_xfer;
   logic             load_ok, point_ok, point_last;

   // Configuration
   logic [CFG_C_W-1:0] centers_ff;
   logic [CFG_B_W-1:0] bins_ff;
   logic [CCNT_W-1:0]  eff_centers;
   logic [BCNT_W-1:0]  eff_bins;

   // Scan counters
   logic [BIN_W-1:0]  b_ff;
   logic [CIDX_W-1:0] c_ff;
   logic [ADDR_W-1:0] addr_ff, base_ff;
   logic              scan_last_bin, scan_last_center;
   ncea_tag_type      tag_issue, tag_rd_ff;

   // Memories
   logic [VAL_W-1:0]  center_mem [CMEM_DEPTH];
   logic [VAL_W-1:0]  point_mem  [MAX_BINS];
   logic [VAL_W-1:0]  center_rd_ff, point_rd_ff;
   logic [ADDR_W-1:0] load_addr;

   // Result
   ncea_best_type     best;
   logic [SUMX_W-1:0] best_ext;
   logic [DIST_W-1:0] best_sat;
   logic              rsp_valid_ff;
   logic [CI_W-1:0]   rsp_center_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              out_free;

   assign req_center = req_tdata[CI_W-1:0];
   assign req_bin    = req_tdata[CI_W+BI_W-1:CI_W];
   assign req_value  = VAL_W'(req_tdata[CI_W+BI_W+BV_W-1:CI_W+BI_W]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Saturate the registers into their working ranges
   always_comb begin
      if (centers_ff == '0) begin
         eff_centers = CCNT_W'(1);
      end else if (32'(centers_ff) > MAX_CENTERS) begin
         eff_centers = CCNT_W'(MAX_CENTERS);
      end else begin
         eff_centers = CCNT_W'(centers_ff);
      end
      if (bins_ff == '0) begin
         eff_bins = BCNT_W'(1);
      end else if (32'(bins_ff) > MAX_BINS) begin
         eff_bins = BCNT_W'(MAX_BINS);
      end else begin
         eff_bins = BCNT_W'(bins_ff);
      end
   end

   // Drop loads and point bins that fall outside the stores
   assign load_ok    = req_xfer && (req_tuser == KIND_CENTER) &&
                       (32'(req_center) < MAX_CENTERS) && (32'(req_bin) < MAX_BINS);
   assign point_ok   = req_xfer && (req_tuser == KIND_POINT) &&
                       (32'(req_bin) < MAX_BINS);
   assign point_last = point_ok && (32'(req_bin) == 32'(eff_bins) - 32'd1);
   assign load_addr  = ADDR_W'(32'(req_center) * MAX_BINS + 32'(req_bin));

   assign scan_last_bin    = (32'(b_ff) == 32'(eff_bins) - 32'd1);
   assign scan_last_center = (32'(c_ff) == 32'(eff_centers) - 32'd1);

   always_comb begin
      tag_issue.valid        = (state_ff == ST_SCAN);
      tag_issue.first_bin    = (b_ff == '0);
      tag_issue.last_bin     = scan_last_bin;
      tag_issue.first_center = (c_ff == '0);
      tag_issue.last_center  = scan_last_center;
      tag_issue.center       = c_ff;
   end

   // Center memory: one write port for loads, one registered read for the scan
   always_ff @(posedge clock) begin
      if (load_ok) begin
         center_mem[load_addr] <= req_value;
      end
      center_rd_ff <= center_mem[addr_ff];
   end

   // Point memory
   always_ff @(posedge clock) begin
      if (point_ok) begin
         point_mem[BIN_W'(req_bin)] <= req_value;
      end
      point_rd_ff <= point_mem[b_ff];
   end

   ncea_emd_unit u_emd (
      .clock      (clock),
      .reset      (reset),
      .tag        (tag_rd_ff),
      .point_bin  (point_rd_ff),
      .center_bin (center_rd_ff),
      .best       (best)
   );

   assign best_ext = SUMX_W'(best.sum);
   assign best_sat = (best_ext > SUMX_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                          : best_ext[DIST_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         centers_ff <= CFG_C_W'(1);
         bins_ff    <= CFG_B_W'(64);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CENTERS_IN_USE) begin
            centers_ff <= csr_data[CFG_C_W-1:0];
         end else if (csr_index == CSR_BINS_IN_USE) begin
            bins_ff <= csr_data[CFG_B_W-1:0];
         end
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_rd_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_rd_ff <= tag_issue;
         // Load a new result, or drop the one that was just taken
         if (state_ff == ST_PUSH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (point_last) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_last_bin && scan_last_center) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (best.done) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      // Address counters: cleared while idle, advance while scanning
      if (state_ff == ST_IDLE) begin
         b_ff    <= '0;
         c_ff    <= '0;
         addr_ff <= '0;
         base_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if (scan_last_bin) begin
            b_ff    <= '0;
            c_ff    <= c_ff + CIDX_W'(1);
            base_ff <= base_ff + ADDR_W'(MAX_BINS);
            addr_ff <= base_ff + ADDR_W'(MAX_BINS);
         end else begin
            b_ff    <= b_ff + BIN_W'(1);
            addr_ff <= addr_ff + ADDR_W'(1);
         end
      end
      if (state_ff == ST_PUSH && out_free) begin
         rsp_center_ff <= CI_W'(best.center);
         rsp_dist_ff   <= best_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_center_ff};

   // Checks
   a_done_in_drain : assert property (@(posedge clock) disable iff (reset)
      best.done |-> state_ff == ST_DRAIN)
      else $error("distance unit finished outside the drain phase");

   a_best_in_range : assert property (@(posedge clock) disable iff (reset)
      best.done |-> 32'(best.center) < 32'(eff_centers))
      else $error("nearest center beyond the centers in use");

   a_scan_start : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && point_last) |=> state_ff == ST_SCAN && b_ff == '0 && c_ff == '0)
      else $error("scan did not start from the first center and bin");

   a_push_loads : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not moved into the output register");

endmodule
